>>> hw/rtl/obst_pkg.sv
// shared constants, item types and helpers for the optimal bst cost block
// no dependencies
`default_nettype none

package obst_pkg;

  localparam int MAX_KEYS    = 16;
  localparam int WEIGHT_BITS = 16;

  // field widths of the item and result
  localparam int IN_W_BITS = 16;
  localparam int COST_W    = 24;
  localparam int ROOT_W    = 5;

  localparam int IDX_W  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CNT_W  = $clog2(MAX_KEYS + 1);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int SUM_W  = WEIGHT_BITS + IDX_W;
  localparam int TOT_W  = ((SUM_W > COST_W) ? SUM_W : COST_W) + 1;

  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  typedef struct packed {
    logic [IN_W_BITS-1:0] weight;
    logic                 last;
  } item_t;

  typedef struct packed {
    logic [COST_W-1:0] total_cost;
    logic [ROOT_W-1:0] root_key;
    logic              overflow;
  } result_t;

  // one entry of the cost / root table
  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic [ROOT_W-1:0] root;
  } entry_t;

  // control from the sequencer to the add-compare unit
  typedef struct packed {
    logic             init;
    logic [IDX_W-1:0] init_k;
    logic             step;
    logic             left_empty;
    logic             right_empty;
    logic [IDX_W-1:0] k;
  } eval_ctrl_t;

  function automatic logic [COST_W-1:0] sat_cost(input logic [TOT_W-1:0] v);
    if (v > TOT_W'(COST_MAX)) begin
      return COST_MAX;
    end
    return v[COST_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/obst_wt_mem.sv
// key weight memory: one write port, one synchronous read port
// depends on obst_pkg
`default_nettype none

module obst_wt_mem (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [obst_pkg::IDX_W-1:0]   wr_addr,
  input  logic [obst_pkg::WEIGHT_BITS-1:0] wr_data,
  input  logic [obst_pkg::IDX_W-1:0]   rd_addr,
  output logic [obst_pkg::WEIGHT_BITS-1:0] rd_data
);
  import obst_pkg::*;

  logic [WEIGHT_BITS-1:0] mem [MAX_KEYS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/obst_dp_mem.sv
// cost / root table memory: one write port, two synchronous read ports
// depends on obst_pkg
`default_nettype none

module obst_dp_mem (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [obst_pkg::ADDR_W-1:0] wr_addr,
  input  obst_pkg::entry_t            wr_data,
  input  logic [obst_pkg::ADDR_W-1:0] rd_a_addr,
  output obst_pkg::entry_t            rd_a_data,
  input  logic [obst_pkg::ADDR_W-1:0] rd_b_addr,
  output obst_pkg::entry_t            rd_b_data
);
  import obst_pkg::*;

  entry_t mem [MAX_KEYS * MAX_KEYS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/obst_eval.sv
// add-compare unit: min over roots of left + right cost, running weight sum
// depends on obst_pkg
`default_nettype none

module obst_eval (
  input  logic                          clk,
  input  obst_pkg::eval_ctrl_t          ctrl,
  input  logic [obst_pkg::COST_W-1:0]   left_cost,
  input  logic [obst_pkg::COST_W-1:0]   right_cost,
  input  logic [obst_pkg::WEIGHT_BITS-1:0] weight,
  output logic [obst_pkg::COST_W-1:0]   entry_cost,
  output logic [obst_pkg::IDX_W-1:0]    best_k
);
  import obst_pkg::*;

  logic [COST_W-1:0] best;
  logic [SUM_W-1:0]  sum;
  logic [COST_W:0]   cand;
  logic [COST_W-1:0] lc;
  logic [COST_W-1:0] rc;

  // empty subtrees cost nothing
  assign lc   = ctrl.left_empty  ? '0 : left_cost;
  assign rc   = ctrl.right_empty ? '0 : right_cost;
  assign cand = {1'b0, lc} + {1'b0, rc};

  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      best   <= COST_MAX;
      best_k <= ctrl.init_k;
      sum    <= '0;
    end else if (ctrl.step) begin
      sum <= sum + SUM_W'(weight);
      // strict compare keeps the smallest root on ties
      if (cand < {1'b0, best}) begin
        best   <= cand[COST_W-1:0];
        best_k <= ctrl.k;
      end
    end
  end

  assign entry_cost = sat_cost(TOT_W'(best) + TOT_W'(sum));

endmodule

`default_nettype wire

>>> hw/rtl/optimal_bst_cost_core.sv
// top level of the optimal bst cost block: sequencer over the table memories
// depends on obst_pkg, obst_wt_mem, obst_dp_mem, obst_eval
//
// usage
//   item channel (item_valid / item_stall / item): one key weight per item, in
//   key order; the item with last set closes the set and starts the solve.
//   keys past MAX_KEYS are dropped and raise the overflow flag of the result.
//   result channel (result_valid / result_stall / result): one result per set,
//   total cost of the optimal tree and its one-based root key.
// sequence
//   while loading, every item offered is taken. after the last item the block fills
//   the cost table interval by interval, shortest intervals first; each interval
//   passes through issue (one root per cycle on the two read ports of the table
//   memory), then a drain state and a write-back state.
//   item_stall stays high from the last item until the result is registered.
// reset
//   rst clears the key count, overflow flag, sequencer and result valid; the
//   memories are not cleared, every entry used is written first in each set.
// stall
//   a waiting result holds in the output register; the next set may load
//   meanwhile, and its solve then waits at the end for the register to free.

`default_nettype none

module optimal_bst_cost_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  obst_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output obst_pkg::result_t result
);
  import obst_pkg::*;

  typedef enum logic [2:0] {
    S_LOAD,
    S_ISSUE,
    S_DRAIN,
    S_WRITE,
    S_RES_RD,
    S_RES_OUT
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;       // keys held in this set
  logic             ovf;       // a key was dropped
  logic [IDX_W-1:0] d;         // interval length minus one
  logic [IDX_W-1:0] i;         // interval start, zero based
  logic [IDX_W-1:0] k;         // root being issued
  eval_ctrl_t       ev;        // control of the add-compare unit
  logic             ev_step;   // read data for a root arrives this cycle
  logic             ev_le;
  logic             ev_re;
  logic [IDX_W-1:0] ev_k;

  logic [IDX_W-1:0] j;
  logic [IDX_W-1:0] nm1;
  logic             accept;
  logic             has_room;
  logic [CNT_W-1:0] cnt_next;
  logic [IDX_W-1:0] cnt_idx;
  logic             out_free;
  logic [IDX_W-1:0] init_k_next;
  logic             init_now;

  logic [WEIGHT_BITS-1:0] wt_in;
  logic [WEIGHT_BITS-1:0] wt_rd;
  logic                   dp_wr_en;
  logic [ADDR_W-1:0]      dp_wr_addr;
  entry_t                 dp_wr_data;
  logic [ADDR_W-1:0]      rd_a_addr;
  logic [ADDR_W-1:0]      rd_b_addr;
  entry_t                 rd_a_data;
  entry_t                 rd_b_data;
  logic [COST_W-1:0]      entry_cost;
  logic [IDX_W-1:0]       best_k;

  assign item_stall = (state != S_LOAD);
  assign accept     = item_valid && !item_stall;
  assign has_room   = (cnt < CNT_W'(MAX_KEYS));
  assign cnt_next   = has_room ? cnt + CNT_W'(1) : cnt;
  assign cnt_idx    = cnt[IDX_W-1:0];
  assign wt_in      = WEIGHT_BITS'(item.weight);
  assign j          = i + d;
  assign nm1        = IDX_W'(cnt - CNT_W'(1));
  assign out_free   = !result_valid || !result_stall;

  // weight memory: written while loading, read at the issued root
  obst_wt_mem u_wt_mem (
    .clk     (clk),
    .wr_en   (accept && has_room),
    .wr_addr (cnt_idx),
    .wr_data (wt_in),
    .rd_addr (k),
    .rd_data (wt_rd)
  );

  // table writes: the diagonal while loading, finished intervals while solving
  always_comb begin
    dp_wr_en   = 1'b0;
    dp_wr_addr = {cnt_idx, cnt_idx};
    dp_wr_data.cost = sat_cost(TOT_W'(wt_in));
    dp_wr_data.root = ROOT_W'(cnt_idx) + ROOT_W'(1);
    if (state == S_WRITE) begin
      dp_wr_en        = 1'b1;
      dp_wr_addr      = {i, j};
      dp_wr_data.cost = entry_cost;
      dp_wr_data.root = ROOT_W'(best_k) + ROOT_W'(1);
    end else if (accept && has_room) begin
      dp_wr_en = 1'b1;
    end
  end

  // port a reads the left subtree while solving, the whole tree at the end
  assign rd_a_addr = (state == S_ISSUE) ? {i, k - IDX_W'(1)} : {IDX_W'(0), nm1};
  assign rd_b_addr = {k + IDX_W'(1), j};

  obst_dp_mem u_dp_mem (
    .clk       (clk),
    .wr_en     (dp_wr_en),
    .wr_addr   (dp_wr_addr),
    .wr_data   (dp_wr_data),
    .rd_a_addr (rd_a_addr),
    .rd_a_data (rd_a_data),
    .rd_b_addr (rd_b_addr),
    .rd_b_data (rd_b_data)
  );

  // the unit restarts when a new interval begins
  always_comb begin
    init_now    = 1'b0;
    init_k_next = '0;
    if (state == S_LOAD && accept && item.last) begin
      init_now = 1'b1;
    end else if (state == S_WRITE) begin
      init_now    = 1'b1;
      init_k_next = (j == nm1) ? IDX_W'(0) : i + IDX_W'(1);
    end
  end

  always_comb begin
    ev.init        = init_now;
    ev.init_k      = init_k_next;
    ev.step        = ev_step;
    ev.left_empty  = ev_le;
    ev.right_empty = ev_re;
    ev.k           = ev_k;
  end

  obst_eval u_eval (
    .clk        (clk),
    .ctrl       (ev),
    .left_cost  (rd_a_data.cost),
    .right_cost (rd_b_data.cost),
    .weight     (wt_rd),
    .entry_cost (entry_cost),
    .best_k     (best_k)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      cnt          <= '0;
      ovf          <= 1'b0;
      d            <= '0;
      i            <= '0;
      k            <= '0;
      ev_step      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      // tag of the root whose reads are in flight
      ev_step <= (state == S_ISSUE);
      ev_le   <= (k == i);
      ev_re   <= (k == j);
      ev_k    <= k;

      // the result state refills the register itself
      if (result_valid && !result_stall && state != S_RES_OUT) begin
        result_valid <= 1'b0;
      end

      case (state)
        S_LOAD: begin
          if (accept) begin
            cnt <= cnt_next;
            if (!has_room) begin
              ovf <= 1'b1;
            end
            if (item.last) begin
              d <= IDX_W'(1);
              i <= '0;
              k <= '0;
              // a single key needs no solve
              state <= (cnt_next == CNT_W'(1)) ? S_RES_RD : S_ISSUE;
            end
          end
        end
        S_ISSUE: begin
          if (k == j) begin
            state <= S_DRAIN;
          end else begin
            k <= k + IDX_W'(1);
          end
        end
        S_DRAIN: begin
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (j == nm1) begin
            // last interval of this length
            if (d == nm1) begin
              state <= S_RES_RD;
            end else begin
              d     <= d + IDX_W'(1);
              i     <= '0;
              k     <= '0;
              state <= S_ISSUE;
            end
          end else begin
            i     <= i + IDX_W'(1);
            k     <= i + IDX_W'(1);
            state <= S_ISSUE;
          end
        end
        S_RES_RD: begin
          state <= S_RES_OUT;
        end
        S_RES_OUT: begin
          if (out_free) begin
            result.total_cost <= rd_a_data.cost;
            result.root_key   <= rd_a_data.root;
            result.overflow   <= ovf;
            result_valid      <= 1'b1;
            cnt               <= '0;
            ovf               <= 1'b0;
            state             <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
